[src/smoothed_log_likelihood_term_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the smoothed log-likelihood term unit
// Immediate-implication and next-cycle-implication checks with reset gating.
// ----------------------------------------------------------------------------
`ifndef SMOOTHED_LOG_LIKELIHOOD_TERM_UNIT_MACROS_SVH
`define SMOOTHED_LOG_LIKELIHOOD_TERM_UNIT_MACROS_SVH

// Check cons in the same cycle as ante
`define SLLT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sllt check failed");

// Check cons in the cycle after ante
`define SLLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sllt check failed");

`endif

[src/sllt_pkg.sv]
// ----------------------------------------------------------------------------
// sllt_pkg
// Widths, constants, shared types and the log2 mantissa table.
// ----------------------------------------------------------------------------
`default_nettype none

package sllt_pkg;

    // Field widths
    localparam int P_BITS      = 33;
    localparam int CNT_IN_BITS = 24;
    localparam int TOL_BITS    = 41;
    localparam int COLS_BITS   = 9;
    localparam int OUT_BITS    = 48;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = TOL_BITS;

    localparam int COUNT_BITS     = 24;
    localparam int LOG_TABLE_BITS = 8;

    // Smoothing datapath
    localparam int PROD_BITS  = TOL_BITS + COLS_BITS;
    localparam int COEF_BITS  = 49;
    localparam int COEF_SPLIT = 24;
    localparam int A_BITS     = COEF_BITS - COEF_SPLIT + P_BITS;
    localparam int B_BITS     = COEF_SPLIT + P_BITS;
    localparam int X_BITS     = 50;
    localparam logic [COEF_BITS-1:0] ONE_Q48 = COEF_BITS'(1) << 48;

    // Log2 datapath
    localparam int E_BITS    = 6;
    localparam int E_BIAS    = 48;
    localparam int F_BITS    = 32;
    localparam int IDX_BITS  = LOG_TABLE_BITS;
    localparam int FRAC_BITS = F_BITS - LOG_TABLE_BITS;
    localparam int TAB_SIZE  = (1 << LOG_TABLE_BITS) + 1;
    localparam int TAB_IDX_BITS = LOG_TABLE_BITS + 1;
    localparam int LOG_FRAC  = 30;
    localparam int LOG_W     = 31;
    localparam int PM_BITS   = LOG_W + FRAC_BITS;
    localparam int L2_BITS   = 38;

    // Natural log and weighting
    localparam int MAG_BITS   = 36;
    localparam int LN2_BITS   = 24;
    localparam logic [LN2_BITS-1:0] LN2_Q24 = 24'd11629080;
    localparam int M_BITS     = MAG_BITS + LN2_BITS;
    localparam int LN_SHIFT   = 38;
    localparam int LNMAG_BITS = 22;
    localparam int LNQ_BITS   = LNMAG_BITS + 1;
    localparam int WPROD_BITS = LNQ_BITS + COUNT_BITS + 1;
    localparam int WSAT_BITS  = (WPROD_BITS > OUT_BITS) ? WPROD_BITS : OUT_BITS + 1;

    // Pipeline shape
    localparam int FRONT_STAGES = 3;
    localparam int LOG_STAGES   = 5;
    localparam int BACK_STAGES  = 5;
    localparam int PIPE_DEPTH   = FRONT_STAGES + LOG_STAGES + BACK_STAGES;
    localparam int OUTS_BITS    = $clog2(PIPE_DEPTH + 1);

    // Register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TOL  = 2'd0,
        CFG_COLS = 2'd1
    } t_cfg_idx;

    localparam logic [TOL_BITS-1:0]  TOL_RESET  = 41'd28147;
    localparam logic [COLS_BITS-1:0] COLS_RESET = 9'd2;

    // Sideband that rides along with each item
    typedef struct packed {
        logic [COUNT_BITS-1:0] cnt;
        logic                  last;
    } t_side;

    typedef logic [LOG_W-1:0] t_log_tab [TAB_SIZE];

    // log2 of y in Q1.30, 1.0 <= y <= 2.0, by repeated squaring
    function automatic logic [LOG_W-1:0] log2_q30(input logic [63:0] y_in);
        logic [63:0]      y;
        logic [LOG_W-1:0] r;
        y = y_in;
        r = '0;
        if (y >= (64'd1 << 31)) begin
            return LOG_W'(1) << LOG_FRAC;
        end
        for (int i = 0; i < LOG_FRAC; i++) begin
            y = (y * y) >> LOG_FRAC;
            r = r << 1;
            if (y >= (64'd1 << 31)) begin
                r[0] = 1'b1;
                y    = y >> 1;
            end
        end
        return r;
    endfunction

    function automatic t_log_tab build_log_tab();
        t_log_tab t;
        for (int k = 0; k < TAB_SIZE; k++) begin
            t[k] = log2_q30((64'd1 << LOG_FRAC) + (64'(k) << (LOG_FRAC - LOG_TABLE_BITS)));
        end
        return t;
    endfunction

    localparam t_log_tab LOG_TAB = build_log_tab();

endpackage

`default_nettype wire

[src/sllt_if.sv]
// ----------------------------------------------------------------------------
// sllt channel interfaces
// Request, response and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface sllt_in_if;
    logic                             valid;
    logic                             ready;
    logic [sllt_pkg::P_BITS-1:0]      probability;
    logic [sllt_pkg::CNT_IN_BITS-1:0] observed_count;
    logic                             last_in;

    modport source (output valid, output probability, output observed_count,
                    output last_in, input ready);
    modport sink   (input valid, input probability, input observed_count,
                    input last_in, output ready);
endinterface

interface sllt_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sllt_pkg::OUT_BITS-1:0] weighted_log;
    logic                                 last_out;

    modport source (output valid, output weighted_log, output last_out, input ready);
    modport sink   (input valid, input weighted_log, input last_out, output ready);
endinterface

interface sllt_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [sllt_pkg::CFG_IDX_BITS-1:0]  index;
    logic [sllt_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/smoothed_log_likelihood_term_unit.sv]
// ----------------------------------------------------------------------------
// smoothed_log_likelihood_term_unit
// Smooths a probability with a tolerance, takes its natural log and weights
// it by the observed count. One request in, one response out.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake        Payload
//  i_req    in         valid / ready    probability, observed_count, last_in
//  o_rsp    out        valid / ready    weighted_log, last_out
//  i_cfg    in         valid / ready    index, data (tol_fraction, response_columns)
//
//  The pipeline has 3 smoothing stages, 5 log2 stages and 5 ln/weight stages.
//  A new request is taken in every cycle while no held response stalls the pipe;
//  the widest multipliers (coef * p, split in two halves) set the stage depth.
//  Reset clears all stage valid bits and loads the default configuration.
//  Each stage advances when it is empty or the one after it advances, so a
//  held response stalls only the full stages behind it; bubbles close up.
//  The configuration port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module smoothed_log_likelihood_term_unit import sllt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sllt_in_if.sink    i_req,
    sllt_out_if.source o_rsp,
    sllt_cfg_if.sink   i_cfg
);

    // Configuration
    logic [TOL_BITS-1:0]  r_tol;
    logic [COLS_BITS-1:0] r_cols;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol  <= TOL_RESET;
            r_cols <= COLS_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_TOL:  r_tol  <= TOL_BITS'(i_cfg.data);
                CFG_COLS: r_cols <= COLS_BITS'(i_cfg.data);
                default:  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Front stages: coefficient, partial products, smoothed value
    // ------------------------------------------------------------------
    logic [FRONT_STAGES-1:0] r_vf;
    logic [FRONT_STAGES-1:0] fe;
    logic                    log_in_ready;
    t_side                   r_fside [FRONT_STAGES];

    logic [COEF_BITS-1:0] r_s1_coef;
    logic [P_BITS-1:0]    r_s1_p;
    logic [TOL_BITS-1:0]  r_s1_tol;
    logic [A_BITS-1:0]    r_s2_a;
    logic [B_BITS-1:0]    r_s2_b;
    logic [TOL_BITS-1:0]  r_s2_tol;
    logic [X_BITS-1:0]    r_s3_x;

    logic [PROD_BITS-1:0] n_s1_prod;
    logic [COEF_BITS-1:0] n_s1_coef;
    logic [B_BITS:0]      lo_sum;
    logic [A_BITS-1:0]    n_s3_sum;
    logic [X_BITS-1:0]    n_s3_x;

    always_comb begin
        fe[FRONT_STAGES-1] = !r_vf[FRONT_STAGES-1] || log_in_ready;
        for (int k = FRONT_STAGES - 2; k >= 0; k--) begin
            fe[k] = !r_vf[k] || fe[k+1];
        end
    end

    assign i_req.ready = fe[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= '0;
        end else begin
            if (fe[0]) begin
                r_vf[0] <= i_req.valid;
            end
            for (int k = 1; k < FRONT_STAGES; k++) begin
                if (fe[k]) begin
                    r_vf[k] <= r_vf[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe[0]) begin
            r_fside[0] <= '{cnt: COUNT_BITS'(i_req.observed_count), last: i_req.last_in};
        end
        for (int k = 1; k < FRONT_STAGES; k++) begin
            if (fe[k]) begin
                r_fside[k] <= r_fside[k-1];
            end
        end
    end

    // Coefficient 1 - tol*cols, clamped at zero
    always_comb begin
        n_s1_prod = PROD_BITS'(r_tol) * PROD_BITS'(r_cols);
        if (n_s1_prod >= PROD_BITS'(ONE_Q48)) begin
            n_s1_coef = '0;
        end else begin
            n_s1_coef = COEF_BITS'(PROD_BITS'(ONE_Q48) - n_s1_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe[0]) begin
            r_s1_coef <= n_s1_coef;
            r_s1_p    <= i_req.probability;
            r_s1_tol  <= r_tol;
        end
    end

    // Upper and lower halves of coef * p
    always_ff @(posedge i_clk) begin
        if (fe[1]) begin
            r_s2_a   <= A_BITS'(r_s1_coef[COEF_BITS-1:COEF_SPLIT]) * A_BITS'(r_s1_p);
            r_s2_b   <= B_BITS'(r_s1_coef[COEF_SPLIT-1:0]) * B_BITS'(r_s1_p);
            r_s2_tol <= r_s1_tol;
        end
    end

    // Exact floor of coef * p / 2^32, add tol, lift zero to one LSB
    always_comb begin
        lo_sum   = ((B_BITS + 1)'(r_s2_a[7:0]) << COEF_SPLIT) + (B_BITS + 1)'(r_s2_b);
        n_s3_sum = (r_s2_a >> (F_BITS - COEF_SPLIT)) + A_BITS'(lo_sum >> F_BITS)
                 + A_BITS'(r_s2_tol);
        n_s3_x   = X_BITS'(n_s3_sum);
        if (n_s3_x == '0) begin
            n_s3_x = X_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe[2]) begin
            r_s3_x <= n_s3_x;
        end
    end

    // ------------------------------------------------------------------
    // Log2 unit
    // ------------------------------------------------------------------
    logic               log_out_valid;
    logic               log_out_ready;
    logic [L2_BITS-1:0] log_l2;
    t_side              log_side;

    sllt_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vf[FRONT_STAGES-1]),
        .o_ready (log_in_ready),
        .i_x     (r_s3_x),
        .i_side  (r_fside[FRONT_STAGES-1]),
        .o_valid (log_out_valid),
        .i_ready (log_out_ready),
        .o_l2    (log_l2),
        .o_side  (log_side)
    );

    // ------------------------------------------------------------------
    // Back stages: magnitude, times ln 2, round, weight, saturate
    // ------------------------------------------------------------------
    logic [BACK_STAGES-1:0] r_vb;
    logic [BACK_STAGES-1:0] be;
    t_side                  r_bside [BACK_STAGES];

    logic                          r_b1_neg;
    logic [MAG_BITS-1:0]           r_b1_mag;
    logic                          r_b2_neg;
    logic [M_BITS-1:0]             r_b2_m;
    logic signed [LNQ_BITS-1:0]    r_b3_lnq;
    logic signed [WPROD_BITS-1:0]  r_b4_w;
    logic signed [OUT_BITS-1:0]    r_b5_w;

    localparam logic [M_BITS:0] LN_ROUND = (M_BITS + 1)'(1) << (LN_SHIFT - 1);
    localparam logic signed [WSAT_BITS-1:0] SAT_HI = WSAT_BITS'(48'sh7FFF_FFFF_FFFF);
    localparam logic signed [WSAT_BITS-1:0] SAT_LO = WSAT_BITS'(48'sh8000_0000_0000);

    logic [LNMAG_BITS-1:0]         n_b3_lnmag;
    logic signed [COUNT_BITS:0]    cnt_s;
    logic signed [WSAT_BITS-1:0]   w_ext;
    logic signed [OUT_BITS-1:0]    n_b5_w;

    always_comb begin
        be[BACK_STAGES-1] = !r_vb[BACK_STAGES-1] || o_rsp.ready;
        for (int k = BACK_STAGES - 2; k >= 0; k--) begin
            be[k] = !r_vb[k] || be[k+1];
        end
    end

    assign log_out_ready = be[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= '0;
        end else begin
            if (be[0]) begin
                r_vb[0] <= log_out_valid;
            end
            for (int k = 1; k < BACK_STAGES; k++) begin
                if (be[k]) begin
                    r_vb[k] <= r_vb[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (be[0]) begin
            r_bside[0] <= log_side;
        end
        for (int k = 1; k < BACK_STAGES; k++) begin
            if (be[k]) begin
                r_bside[k] <= r_bside[k-1];
            end
        end
    end

    // Split sign and magnitude of the log2 value
    always_ff @(posedge i_clk) begin
        if (be[0]) begin
            r_b1_neg <= log_l2[L2_BITS-1];
            r_b1_mag <= log_l2[L2_BITS-1] ? MAG_BITS'(L2_BITS'(0) - log_l2)
                                          : MAG_BITS'(log_l2);
        end
    end

    // Scale by ln 2
    always_ff @(posedge i_clk) begin
        if (be[1]) begin
            r_b2_neg <= r_b1_neg;
            r_b2_m   <= M_BITS'(r_b1_mag) * M_BITS'(LN2_Q24);
        end
    end

    // Round half up on the magnitude to Q.16, then restore the sign
    always_comb begin
        n_b3_lnmag = LNMAG_BITS'(((M_BITS + 1)'(r_b2_m) + LN_ROUND) >> LN_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (be[2]) begin
            r_b3_lnq <= r_b2_neg ? LNQ_BITS'(0) - LNQ_BITS'(n_b3_lnmag)
                                 : LNQ_BITS'(n_b3_lnmag);
        end
    end

    // Weight by the count
    assign cnt_s = $signed({1'b0, r_bside[2].cnt});

    always_ff @(posedge i_clk) begin
        if (be[3]) begin
            r_b4_w <= r_b3_lnq * cnt_s;
        end
    end

    // Saturate to the output range
    always_comb begin
        w_ext = WSAT_BITS'(r_b4_w);
        if (w_ext > SAT_HI) begin
            n_b5_w = OUT_BITS'(SAT_HI);
        end else if (w_ext < SAT_LO) begin
            n_b5_w = OUT_BITS'(SAT_LO);
        end else begin
            n_b5_w = OUT_BITS'(w_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (be[4]) begin
            r_b5_w <= n_b5_w;
        end
    end

    assign o_rsp.valid        = r_vb[BACK_STAGES-1];
    assign o_rsp.weighted_log = r_b5_w;
    assign o_rsp.last_out     = r_bside[BACK_STAGES-1].last;

endmodule

`default_nettype wire

[src/sllt_log2.sv]
// ----------------------------------------------------------------------------
// sllt_log2
// Five-stage fixed-point log2: leading-one search, normalize, table read,
// interpolation multiply, exponent merge. Output is Q.30, two's complement.
// ----------------------------------------------------------------------------
`default_nettype none

module sllt_log2 import sllt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [X_BITS-1:0]   i_x,
    input  t_side               i_side,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [L2_BITS-1:0]  o_l2,
    output t_side               o_side
);

    logic [LOG_STAGES-1:0] r_v;
    logic [LOG_STAGES-1:0] en;
    t_side                 r_side [LOG_STAGES];

    logic [X_BITS-1:0]    r_l1_x;
    logic [E_BITS-1:0]    r_l1_e;
    logic [F_BITS-1:0]    r_l2_f;
    logic [E_BITS-1:0]    r_l2_e;
    logic [LOG_W-1:0]     r_l3_l0;
    logic [LOG_W-1:0]     r_l3_diff;
    logic [FRAC_BITS-1:0] r_l3_frac;
    logic [E_BITS-1:0]    r_l3_e;
    logic [PM_BITS-1:0]   r_l4_pm;
    logic [LOG_W-1:0]     r_l4_l0;
    logic [E_BITS-1:0]    r_l4_e;
    logic [L2_BITS-1:0]   r_l5_l2;

    logic [E_BITS-1:0]       n_l1_e;
    logic [F_BITS-1:0]       n_l2_f;
    logic [TAB_IDX_BITS-1:0] lo_idx;
    logic [TAB_IDX_BITS-1:0] hi_idx;
    logic [LOG_W-1:0]        n_l3_l0;
    logic [LOG_W-1:0]        n_l3_l1;
    logic [L2_BITS-1:0]      n_l5_l2;

    // Advance a stage when it is empty or the next one advances
    always_comb begin
        en[LOG_STAGES-1] = !r_v[LOG_STAGES-1] || i_ready;
        for (int k = LOG_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[LOG_STAGES-1];
    assign o_l2    = r_l5_l2;
    assign o_side  = r_side[LOG_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < LOG_STAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_side[0] <= i_side;
        end
        for (int k = 1; k < LOG_STAGES; k++) begin
            if (en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Find the leading one
    always_comb begin
        n_l1_e = '0;
        for (int i = 0; i < X_BITS; i++) begin
            if (i_x[i]) begin
                n_l1_e = E_BITS'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_l1_x <= i_x;
            r_l1_e <= n_l1_e;
        end
    end

    // Normalize: 32 fraction bits below the leading one
    always_comb begin
        if (r_l1_e >= E_BITS'(F_BITS)) begin
            n_l2_f = F_BITS'(r_l1_x >> (r_l1_e - E_BITS'(F_BITS)));
        end else begin
            n_l2_f = F_BITS'(r_l1_x[F_BITS-1:0] << (E_BITS'(F_BITS) - r_l1_e));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_l2_f <= n_l2_f;
            r_l2_e <= r_l1_e;
        end
    end

    // Read the two neighboring table entries
    always_comb begin
        lo_idx  = {1'b0, r_l2_f[F_BITS-1 -: IDX_BITS]};
        hi_idx  = lo_idx + TAB_IDX_BITS'(1);
        n_l3_l0 = LOG_TAB[lo_idx];
        n_l3_l1 = LOG_TAB[hi_idx];
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_l3_l0   <= n_l3_l0;
            r_l3_diff <= n_l3_l1 - n_l3_l0;
            r_l3_frac <= r_l2_f[FRAC_BITS-1:0];
            r_l3_e    <= r_l2_e;
        end
    end

    // Weight the table step by the remaining fraction
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_l4_pm <= PM_BITS'(r_l3_diff) * PM_BITS'(r_l3_frac);
            r_l4_l0 <= r_l3_l0;
            r_l4_e  <= r_l3_e;
        end
    end

    // Merge mantissa log and unbiased exponent
    always_comb begin
        n_l5_l2 = L2_BITS'(r_l4_l0) + L2_BITS'(r_l4_pm >> FRAC_BITS)
                + ((L2_BITS'(r_l4_e) - L2_BITS'(E_BIAS)) << LOG_FRAC);
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_l5_l2 <= n_l5_l2;
        end
    end

endmodule

`default_nettype wire

[src/sllt_checker.sv]
// ----------------------------------------------------------------------------
// sllt_checker
// Port-level checks on the request and response channels, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "smoothed_log_likelihood_term_unit_macros.svh"

module sllt_checker import sllt_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_ready,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire logic [OUT_BITS-1:0] i_out_data,
    input wire logic                i_out_last
);

    logic                 in_acc;
    logic                 out_acc;
    logic                 rsp_held;
    logic                 has_room;
    logic [OUTS_BITS-1:0] r_outstanding;
    logic [OUTS_BITS-1:0] n_outstanding;

    assign in_acc   = i_in_valid && i_in_ready;
    assign out_acc  = i_out_valid && i_out_ready;
    assign rsp_held = i_out_valid && !i_out_ready;
    assign has_room = (r_outstanding < OUTS_BITS'(PIPE_DEPTH)) || out_acc;

    // Track requests taken but not yet answered
    always_comb begin
        n_outstanding = r_outstanding;
        if (in_acc && !out_acc) begin
            n_outstanding = r_outstanding + OUTS_BITS'(1);
        end else if (!in_acc && out_acc) begin
            n_outstanding = r_outstanding - OUTS_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= n_outstanding;
        end
    end

    // Held response keeps valid and payload
    `SLLT_ASSERT_NEXT(a_rsp_valid_hold, i_clk, i_rst_n, rsp_held, i_out_valid)
    `SLLT_ASSERT_NEXT(a_rsp_data_hold, i_clk, i_rst_n, rsp_held, $stable({i_out_data, i_out_last}))

    // No response without a pending request
    `SLLT_ASSERT_SAME(a_no_orphan, i_clk, i_rst_n, i_out_valid, r_outstanding != '0)

    // A full pipeline takes a request only while it hands one out
    `SLLT_ASSERT_SAME(a_depth_bound, i_clk, i_rst_n, in_acc, has_room)

endmodule

bind smoothed_log_likelihood_term_unit sllt_checker u_sllt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_data  (o_rsp.weighted_log),
    .i_out_last  (o_rsp.last_out)
);

`default_nettype wire

[test/tb_smoothed_log_likelihood_term_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smoothed_log_likelihood_term_unit
// Streams probability/count requests through the unit and checks each
// response against a bit-exact predictor of the smoothing, the table log2,
// the ln 2 scaling and the count weighting. Register settings change between
// phases while the pipeline is empty, including clamp and floor corners.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_smoothed_log_likelihood_term_unit;

    localparam int CLK_PERIOD   = 12;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 10;

    localparam int P_W    = sllt_pkg::P_BITS;
    localparam int CNT_W  = sllt_pkg::CNT_IN_BITS;
    localparam int OUT_W  = sllt_pkg::OUT_BITS;
    localparam int IDX_W  = sllt_pkg::CFG_IDX_BITS;
    localparam int DATA_W = sllt_pkg::CFG_DATA_BITS;
    localparam int KNOT_BITS = sllt_pkg::LOG_TABLE_BITS;
    localparam int KNOTS     = (1 << KNOT_BITS) + 1;

    // Register indexes with no register behind them
    localparam logic [IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam logic [40:0] DEFAULT_TOL  = 41'd28147;
    localparam logic [8:0]  DEFAULT_COLS = 9'd2;
    localparam logic [40:0] TOL_ALL_ONES = '1;
    localparam logic [63:0] UNITY_Q48    = 64'd1 << 48;
    localparam logic [63:0] LN2_SCALED   = 64'd11629080;
    localparam longint      TERM_MAX     = (longint'(1) << 47) - 1;
    localparam longint      TERM_MIN     = -(longint'(1) << 47);
    localparam logic [P_W-1:0]   P_ONE     = 33'h1_0000_0000;
    localparam logic [P_W-1:0]   P_MAX     = '1;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [P_W-1:0]   prob;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_term_req;

    typedef struct packed {
        logic signed [OUT_W-1:0] wlog;
        logic                    last;
    } t_term_rsp;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] data;
    } t_reg_write;

    logic i_clk;
    logic i_rst_n;

    sllt_in_if  req_if ();
    sllt_out_if rsp_if ();
    sllt_cfg_if cfg_if ();

    smoothed_log_likelihood_term_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source),
        .i_cfg   (cfg_if.sink)
    );

    // Predictor copy of the registers and the log2 knot table
    logic [40:0] model_tol;
    logic [8:0]  model_cols;
    logic [31:0] log2_knots [KNOTS];

    t_term_req  pending_reqs [$];
    t_term_rsp  expected_terms [$];
    t_reg_write pending_writes [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int reqs_sent      = 0;
    int terms_checked  = 0;
    int regs_written   = 0;
    int error_count    = 0;

    // log2(1 + k/2^KNOT_BITS) in Q1.30, one result bit per squaring
    function automatic logic [31:0] log2_of_knot(input int k);
        logic [63:0] y;
        logic [31:0] bits;
        y    = (64'd1 << 30) + (64'(k) << (30 - KNOT_BITS));
        bits = '0;
        if (y >= (64'd1 << 31)) begin
            return 32'd1 << 30;
        end
        for (int b = 29; b >= 0; b--) begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31)) begin
                bits[b] = 1'b1;
                y       = y >> 1;
            end
        end
        return bits;
    endfunction

    // count * ln(smoothed probability), Q.16, saturated to 48 bits
    function automatic t_term_rsp smoothed_ln_term(input logic [P_W-1:0] prob,
                                                   input logic [CNT_W-1:0] count,
                                                   input logic last);
        logic [49:0] tol_x_cols;
        logic [48:0] coef;
        logic [81:0] coef_x_p;
        logic [63:0] p_adj;
        logic [31:0] mant;
        logic [31:0] lo_knot;
        logic [31:0] hi_knot;
        logic [63:0] step;
        logic [63:0] mag;
        logic [63:0] ln_mag;
        int          lead;
        int          slot;
        longint      log2_q30;
        longint      ln_q16;
        longint      term;
        t_term_rsp   r;
        tol_x_cols = 50'(model_tol) * 50'(model_cols);
        coef = (64'(tol_x_cols) >= UNITY_Q48) ? '0 : 49'(UNITY_Q48 - 64'(tol_x_cols));
        coef_x_p = 82'(coef) * 82'(prob);
        p_adj = 64'(coef_x_p >> 32) + 64'(model_tol);
        // floor at one LSB so the log stays finite
        if (p_adj == 0) begin
            p_adj = 64'd1;
        end
        lead = 63;
        while (!p_adj[lead]) begin
            lead--;
        end
        if (lead >= 32) begin
            mant = 32'(p_adj >> (lead - 32));
        end else begin
            mant = 32'(p_adj << (32 - lead));
        end
        // interpolate between neighboring knots
        slot    = int'(mant >> (32 - KNOT_BITS));
        lo_knot = log2_knots[slot];
        hi_knot = log2_knots[slot + 1];
        step = (64'(hi_knot - lo_knot) * 64'(mant & ((32'd1 << (32 - KNOT_BITS)) - 1)))
               >> (32 - KNOT_BITS);
        log2_q30 = longint'({32'd0, lo_knot}) + longint'(step)
                   + longint'(lead - 48) * (longint'(1) << 30);
        // scale by ln 2, round half up on the magnitude
        mag    = (log2_q30 < 0) ? 64'(-log2_q30) : 64'(log2_q30);
        ln_mag = (mag * LN2_SCALED + (64'd1 << 37)) >> 38;
        ln_q16 = (log2_q30 < 0) ? -longint'(ln_mag) : longint'(ln_mag);
        term   = ln_q16 * longint'({40'd0, count});
        if (term > TERM_MAX) begin
            term = TERM_MAX;
        end
        if (term < TERM_MIN) begin
            term = TERM_MIN;
        end
        r.wlog = term[OUT_W-1:0];
        r.last = last;
        return r;
    endfunction

    function automatic logic [P_W-1:0] rand_probability();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return '0;
            1: return P_ONE;
            2, 3: return P_W'(raw[P_W-1:0] >> $urandom_range(0, P_W - 1));
            4: return P_ONE - P_W'($urandom_range(0, 1000));
            5: return raw[P_W-1:0];
            default: return P_W'(raw[31:0]);
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] rand_count();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return COUNT_MAX;
            2, 3: return CNT_W'($urandom_range(0, 255));
            default: return CNT_W'($urandom);
        endcase
    endfunction

    task automatic push_item(input logic [P_W-1:0] prob, input logic [CNT_W-1:0] count,
                             input logic last);
        pending_reqs.push_back('{prob: prob, count: count, last: last});
    endtask

    task automatic push_random(input int n);
        repeat (n) begin
            push_item(rand_probability(), rand_count(), $urandom_range(0, 15) == 0);
        end
    endtask

    task automatic queue_write(input logic [IDX_W-1:0] index, input logic [DATA_W-1:0] data);
        pending_writes.push_back('{index: index, data: data});
    endtask

    // Hold until every queued register write has been taken
    task automatic wait_writes();
        do @(posedge i_clk);
        while (pending_writes.size() != 0 || cfg_if.valid);
    endtask

    // Hold until every request is sent and every response has come back
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || req_if.valid || expected_terms.size() != 0);
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Request driver: score taken requests, then present the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_terms.push_back(smoothed_ln_term(req_if.probability,
                                                          req_if.observed_count,
                                                          req_if.last_in));
                reqs_sent++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    req_if.probability    <= pending_reqs[0].prob;
                    req_if.observed_count <= pending_reqs[0].count;
                    req_if.last_in        <= pending_reqs[0].last;
                    req_if.valid          <= 1'b1;
                    void'(pending_reqs.pop_front());
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Register write driver: update the predictor copy on each taken write
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_if.valid <= 1'b0;
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    sllt_pkg::CFG_TOL:  model_tol  <= cfg_if.data;
                    sllt_pkg::CFG_COLS: model_cols <= cfg_if.data[8:0];
                    default: ;
                endcase
                regs_written++;
            end
            if (!cfg_if.valid || cfg_if.ready) begin
                if (pending_writes.size() != 0) begin
                    cfg_if.index <= pending_writes[0].index;
                    cfg_if.data  <= pending_writes[0].data;
                    cfg_if.valid <= 1'b1;
                    void'(pending_writes.pop_front());
                end else begin
                    cfg_if.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: compare against the oldest prediction, stall at random
    always @(posedge i_clk) begin : rsp_monitor
        t_term_rsp want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_terms.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_MAX) begin
                        $display("ERROR: response with nothing expected: wlog=%0d last=%0b",
                                 rsp_if.weighted_log, rsp_if.last_out);
                    end
                end else begin
                    want = expected_terms.pop_front();
                    terms_checked++;
                    if (rsp_if.weighted_log !== want.wlog || rsp_if.last_out !== want.last) begin
                        error_count++;
                        if (error_count <= REPORT_MAX) begin
                            $display("ERROR: response %0d: expected %0d/%0b, got %0d/%0b",
                                     terms_checked, want.wlog, want.last,
                                     rsp_if.weighted_log, rsp_if.last_out);
                        end
                    end
                end
            end
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("tb_smoothed_log_likelihood_term_unit: done, errors");
        $finish;
    end

    // Stimulus and phase sequencing
    initial begin
        logic [DATA_W-1:0] tol_pick;
        req_if.valid          = 1'b0;
        req_if.probability    = '0;
        req_if.observed_count = '0;
        req_if.last_in        = 1'b0;
        rsp_if.ready          = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = '0;
        cfg_if.data           = '0;
        model_tol             = DEFAULT_TOL;
        model_cols            = DEFAULT_COLS;
        for (int k = 0; k < KNOTS; k++) begin
            log2_knots[k] = log2_of_knot(k);
        end
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender rarely idles, receiver mostly stalls
        send_idle_pct  = 6;
        recv_stall_pct = 72;

        // default settings: field extremes and a walking leading one
        push_item('0, COUNT_MAX, 1'b0);
        push_item('0, 24'd1, 1'b0);
        push_item(33'd1, COUNT_MAX, 1'b0);
        push_item(P_ONE, COUNT_MAX, 1'b0);
        push_item(P_ONE - 33'd1, COUNT_MAX, 1'b1);
        push_item(P_MAX, COUNT_MAX, 1'b0);
        push_item(P_ONE + (P_ONE >> 1), 24'd1000, 1'b0);
        push_item(P_ONE >> 1, '0, 1'b0);
        push_item(P_ONE >> 1, 24'd1, 1'b1);
        push_item(33'h1_5555_5555, 24'h555555, 1'b0);
        push_item(33'h0_AAAA_AAAA, 24'hAAAAAA, 1'b1);
        push_item(33'd1 << 3, COUNT_MAX, 1'b0);
        push_item(33'd1 << 10, 24'd77, 1'b0);
        push_item(33'd1 << 17, COUNT_MAX, 1'b0);
        push_item(33'd1 << 24, 24'd3, 1'b0);
        push_item(33'd1 << 29, COUNT_MAX, 1'b1);
        wait_drained();

        // columns zero: coefficient is exactly one
        queue_write(sllt_pkg::CFG_COLS, '0);
        wait_writes();
        push_random(48);
        wait_drained();

        // tolerance times columns far above one: coefficient clamps to zero
        queue_write(sllt_pkg::CFG_TOL, TOL_ALL_ONES);
        queue_write(sllt_pkg::CFG_COLS, 41'd511);
        wait_writes();
        push_random(48);
        wait_drained();

        // swap the idling pattern
        send_idle_pct  = 72;
        recv_stall_pct = 6;

        // tolerance times columns exactly one
        queue_write(sllt_pkg::CFG_TOL, 41'd1 << 40);
        queue_write(sllt_pkg::CFG_COLS, 41'd256);
        wait_writes();
        push_random(24);
        wait_drained();

        // no tolerance: zero probability falls to the one-LSB floor
        queue_write(sllt_pkg::CFG_TOL, '0);
        queue_write(sllt_pkg::CFG_COLS, 41'd1);
        wait_writes();
        push_item('0, COUNT_MAX, 1'b1);
        push_item('0, 24'd1, 1'b0);
        push_random(24);
        wait_drained();

        // writes to unused indexes must leave the settings alone
        queue_write(CFG_SPARE_2, {$urandom, $urandom});
        queue_write(CFG_SPARE_3, TOL_ALL_ONES);
        wait_writes();
        push_random(24);
        // hold the sender until every response is back, then resume
        wait_drained();
        push_random(24);
        wait_drained();

        // random settings; columns writes carry junk above bit 8
        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 2) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            tol_pick = DATA_W'({$urandom, $urandom}) >> $urandom_range(0, DATA_W - 1);
            queue_write(sllt_pkg::CFG_TOL, tol_pick);
            queue_write(sllt_pkg::CFG_COLS,
                        {DATA_W'($urandom) << 9} | DATA_W'($urandom_range(1, 256)));
            wait_writes();
            push_random(48);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        error_count += expected_terms.size();

        $display("Summary: %0d requests, %0d responses checked, %0d register writes, %0d cycles",
                 reqs_sent, terms_checked, regs_written, cycle_count);
        $display("Covered %s, %s",
                 "clamped and exact-one coefficients, zero floor, zero columns",
                 "above-one probabilities and unused register indexes");
        if (error_count == 0) begin
            $display("tb_smoothed_log_likelihood_term_unit: done, clean");
        end else begin
            $display("tb_smoothed_log_likelihood_term_unit: done, errors");
        end
        $finish;
    end

endmodule
